[src/vtmc_pkg.sv]
`default_nettype none

package vtmc_pkg;

    localparam int TEMP_W = 12;
    localparam int MS_W   = 20;
    localparam int CFG_IDX_W = 2;

    // input commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_BUTTON = 2'd2;

    // buttons
    localparam logic [1:0] BTN_UP   = 2'd0;
    localparam logic [1:0] BTN_DOWN = 2'd1;
    localparam logic [1:0] BTN_OK   = 2'd2;
    localparam logic [1:0] BTN_MODE = 2'd3;

    // menu states
    localparam logic [1:0] MENU_HOME   = 2'd0;
    localparam logic [1:0] MENU_SELECT = 2'd1;
    localparam logic [1:0] MENU_LOWER  = 2'd2;
    localparam logic [1:0] MENU_UPPER  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT_TO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MENU_TO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_RUN    = 2'd2;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -12'sd550;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sd1250;
    localparam logic [MS_W-1:0] MS_MAX = '1;

    localparam logic [MS_W-1:0] BACKLIGHT_TO_RST = 20'd30000;
    localparam logic [MS_W-1:0] MENU_TO_RST      = 20'd60000;
    localparam logic [MS_W-1:0] RELAY_RUN_RST    = 20'd100000;

    localparam logic signed [TEMP_W-1:0] LOW_RST  = 12'sd240;
    localparam logic signed [TEMP_W-1:0] HIGH_RST = 12'sd260;
    localparam logic signed [TEMP_W-1:0] TEMP_RST = 12'sd239;

    typedef struct packed {
        logic [MS_W-1:0] backlight_to;
        logic [MS_W-1:0] menu_to;
        logic [MS_W-1:0] relay_run;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               menu_mode;
        logic                     auto_on;
        logic                     vent_open;
        logic                     backlight_on;
        logic signed [TEMP_W-1:0] lower_limit;
        logic signed [TEMP_W-1:0] upper_limit;
        logic                     drive_open;
        logic                     drive_close;
        logic                     drive_common;
        logic signed [TEMP_W-1:0] current_temp;
    } res_t;

endpackage

`default_nettype wire

[src/vtmc_cfg_regs.sv]
`default_nettype none

module vtmc_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [vtmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vtmc_pkg::MS_W-1:0]        cfg_data,
    output vtmc_pkg::cfg_t                        cfg
);

    logic [vtmc_pkg::MS_W-1:0] backlight_to_reg;
    logic [vtmc_pkg::MS_W-1:0] menu_to_reg;
    logic [vtmc_pkg::MS_W-1:0] relay_run_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlight_to_reg <= vtmc_pkg::BACKLIGHT_TO_RST;
            menu_to_reg      <= vtmc_pkg::MENU_TO_RST;
            relay_run_reg    <= vtmc_pkg::RELAY_RUN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vtmc_pkg::CFG_BACKLIGHT_TO: backlight_to_reg <= cfg_data;
                vtmc_pkg::CFG_MENU_TO:      menu_to_reg      <= cfg_data;
                vtmc_pkg::CFG_RELAY_RUN:    relay_run_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign cfg.backlight_to = backlight_to_reg;
    assign cfg.menu_to      = menu_to_reg;
    assign cfg.relay_run    = relay_run_reg;

endmodule

`default_nettype wire

[src/vtmc_core.sv]
`default_nettype none

module vtmc_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step,
    input  wire logic [1:0]                         cmd,
    input  wire logic [1:0]                         button,
    input  wire logic signed [vtmc_pkg::TEMP_W-1:0] temp_sample,
    input  wire vtmc_pkg::cfg_t                     cfg,
    output vtmc_pkg::res_t                          res_next
);

    logic [1:0]                          menu_reg,  menu_next;
    logic                                auto_reg,  auto_next;
    logic                                open_reg,  open_next;
    logic                                light_reg, light_next;
    logic [vtmc_pkg::MS_W-1:0]           idle_reg,  idle_next;
    logic signed [vtmc_pkg::TEMP_W-1:0]  low_reg,   low_next;
    logic signed [vtmc_pkg::TEMP_W-1:0]  high_reg,  high_next;
    logic signed [vtmc_pkg::TEMP_W-1:0]  temp_reg,  temp_next;
    logic [vtmc_pkg::MS_W-1:0]           run_reg,   run_next;
    logic                                dir_reg,   dir_next;
    logic                                running;

    always_comb
    begin
        menu_next  = menu_reg;
        auto_next  = auto_reg;
        open_next  = open_reg;
        light_next = light_reg;
        idle_next  = idle_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        temp_next  = temp_reg;
        run_next   = run_reg;
        dir_next   = dir_reg;

        case (cmd)
            vtmc_pkg::CMD_TICK:
            begin
                if (idle_reg != vtmc_pkg::MS_MAX)
                    idle_next = idle_reg + 1'b1;
                if (light_reg && idle_next >= cfg.backlight_to)
                    light_next = 1'b0;
                if (idle_next >= cfg.menu_to)
                    menu_next = vtmc_pkg::MENU_HOME;
                if (run_reg != '0)
                    run_next = run_reg - 1'b1;
            end
            vtmc_pkg::CMD_SAMPLE:
            begin
                if (temp_sample < vtmc_pkg::TEMP_MIN)
                    temp_next = vtmc_pkg::TEMP_MIN;
                else if (temp_sample > vtmc_pkg::TEMP_MAX)
                    temp_next = vtmc_pkg::TEMP_MAX;
                else
                    temp_next = temp_sample;
            end
            vtmc_pkg::CMD_BUTTON:
            begin
                idle_next = '0;
                // a press on a dark display only wakes it
                if (!light_reg)
                    light_next = 1'b1;
                else
                begin
                    case (menu_reg)
                        vtmc_pkg::MENU_HOME:
                        begin
                            if (button == vtmc_pkg::BTN_UP)
                            begin
                                if (!auto_reg && !open_reg)
                                begin
                                    open_next = 1'b1;
                                    dir_next  = 1'b1;
                                    run_next  = cfg.relay_run;
                                end
                            end
                            else if (button == vtmc_pkg::BTN_DOWN)
                            begin
                                if (!auto_reg && open_reg)
                                begin
                                    open_next = 1'b0;
                                    dir_next  = 1'b0;
                                    run_next  = cfg.relay_run;
                                end
                            end
                            else if (button == vtmc_pkg::BTN_MODE)
                                menu_next = vtmc_pkg::MENU_SELECT;
                        end
                        vtmc_pkg::MENU_SELECT:
                        begin
                            if (button == vtmc_pkg::BTN_OK)
                            begin
                                auto_next = !auto_reg;
                                menu_next = vtmc_pkg::MENU_HOME;
                            end
                            else if (button == vtmc_pkg::BTN_MODE)
                                menu_next = vtmc_pkg::MENU_LOWER;
                        end
                        vtmc_pkg::MENU_LOWER:
                        begin
                            if (button == vtmc_pkg::BTN_UP)
                                low_next = (low_reg >= vtmc_pkg::TEMP_MAX) ?
                                           vtmc_pkg::TEMP_MAX : low_reg + 12'sd1;
                            else if (button == vtmc_pkg::BTN_DOWN)
                                low_next = (low_reg <= vtmc_pkg::TEMP_MIN) ?
                                           vtmc_pkg::TEMP_MIN : low_reg - 12'sd1;
                            else if (button == vtmc_pkg::BTN_OK)
                                menu_next = vtmc_pkg::MENU_HOME;
                            else
                                menu_next = vtmc_pkg::MENU_UPPER;
                        end
                        default:
                        begin
                            if (button == vtmc_pkg::BTN_UP)
                                high_next = (high_reg >= vtmc_pkg::TEMP_MAX) ?
                                            vtmc_pkg::TEMP_MAX : high_reg + 12'sd1;
                            else if (button == vtmc_pkg::BTN_DOWN)
                                high_next = (high_reg <= vtmc_pkg::TEMP_MIN) ?
                                            vtmc_pkg::TEMP_MIN : high_reg - 12'sd1;
                            else
                                menu_next = vtmc_pkg::MENU_HOME;
                        end
                    endcase
                end
            end
            default: ;
        endcase

        // automatic control sees the state left by this beat
        if (auto_next)
        begin
            if (temp_next > high_next && !open_next)
            begin
                open_next = 1'b1;
                dir_next  = 1'b1;
                run_next  = cfg.relay_run;
            end
            else if (temp_next < low_next && open_next)
            begin
                open_next = 1'b0;
                dir_next  = 1'b0;
                run_next  = cfg.relay_run;
            end
        end
    end

    assign running = (run_next != '0);

    assign res_next.menu_mode    = menu_next;
    assign res_next.auto_on      = auto_next;
    assign res_next.vent_open    = open_next;
    assign res_next.backlight_on = light_next;
    assign res_next.lower_limit  = low_next;
    assign res_next.upper_limit  = high_next;
    assign res_next.drive_open   = running & dir_next;
    assign res_next.drive_close  = running & !dir_next;
    assign res_next.drive_common = running;
    assign res_next.current_temp = temp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            menu_reg  <= vtmc_pkg::MENU_HOME;
            auto_reg  <= 1'b1;
            open_reg  <= 1'b0;
            light_reg <= 1'b0;
            idle_reg  <= '0;
            low_reg   <= vtmc_pkg::LOW_RST;
            high_reg  <= vtmc_pkg::HIGH_RST;
            temp_reg  <= vtmc_pkg::TEMP_RST;
            run_reg   <= '0;
            dir_reg   <= 1'b0;
        end
        else if (step)
        begin
            menu_reg  <= menu_next;
            auto_reg  <= auto_next;
            open_reg  <= open_next;
            light_reg <= light_next;
            idle_reg  <= idle_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            temp_reg  <= temp_next;
            run_reg   <= run_next;
            dir_reg   <= dir_next;
        end
    end

    a_low_range: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg >= vtmc_pkg::TEMP_MIN && low_reg <= vtmc_pkg::TEMP_MAX)
        else $error("lower limit out of range");

    a_high_range: assert property (@(posedge clk) disable iff (!rst_n)
        high_reg >= vtmc_pkg::TEMP_MIN && high_reg <= vtmc_pkg::TEMP_MAX)
        else $error("upper limit out of range");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        temp_reg >= vtmc_pkg::TEMP_MIN && temp_reg <= vtmc_pkg::TEMP_MAX)
        else $error("stored temperature out of range");

    a_press_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && cmd == vtmc_pkg::CMD_BUTTON) |=> (idle_reg == '0))
        else $error("button beat did not clear idle timer");

    a_dark_press_wakes_only: assert property (@(posedge clk) disable iff (!rst_n)
        (step && cmd == vtmc_pkg::CMD_BUTTON && !light_reg)
        |=> (light_reg && $stable(menu_reg) && $stable(low_reg) && $stable(high_reg)))
        else $error("press on dark display changed the menu");

endmodule

`default_nettype wire

[src/vent_thermostat_menu_controller_top.sv]
`default_nettype none

// path: an accepted input beat is held in the input register, then its result in the
// result register; a stall on the result side can hold the beat in the input register
// throughput: one input beat per cycle while the result side keeps taking beats
// reset: rst_n clears all state and the timeout/run registers to their defaults
// and empties both pipeline registers; no beat is held across reset

module vent_thermostat_menu_controller_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vtmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vtmc_pkg::MS_W-1:0]          cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         cmd,
    input  wire logic [1:0]                         button,
    input  wire logic signed [vtmc_pkg::TEMP_W-1:0] temp_sample,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [1:0]                              menu_mode,
    output logic                                    auto_on,
    output logic                                    vent_open,
    output logic                                    backlight_on,
    output logic signed [vtmc_pkg::TEMP_W-1:0]      lower_limit,
    output logic signed [vtmc_pkg::TEMP_W-1:0]      upper_limit,
    output logic                                    drive_open,
    output logic                                    drive_close,
    output logic                                    drive_common,
    output logic signed [vtmc_pkg::TEMP_W-1:0]      current_temp
);

    vtmc_pkg::cfg_t cfg;
    vtmc_pkg::res_t res_next;
    vtmc_pkg::res_t res_reg;

    logic                               in_valid_reg, in_valid_next;
    logic [1:0]                         cmd_reg;
    logic [1:0]                         button_reg;
    logic signed [vtmc_pkg::TEMP_W-1:0] sample_reg;
    logic                               out_valid_reg, out_valid_next;
    logic                               step;
    logic                               in_take;

    vtmc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vtmc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .cmd         (cmd_reg),
        .button      (button_reg),
        .temp_sample (sample_reg),
        .cfg         (cfg),
        .res_next    (res_next)
    );

    // the held beat moves on when the result register is free or being drained
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;
    assign in_take  = in_valid && in_ready;

    assign in_valid_next  = in_take || (in_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg    <= cmd;
            button_reg <= button;
            sample_reg <= temp_sample;
        end
        if (step)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign menu_mode    = res_reg.menu_mode;
    assign auto_on      = res_reg.auto_on;
    assign vent_open    = res_reg.vent_open;
    assign backlight_on = res_reg.backlight_on;
    assign lower_limit  = res_reg.lower_limit;
    assign upper_limit  = res_reg.upper_limit;
    assign drive_open   = res_reg.drive_open;
    assign drive_close  = res_reg.drive_close;
    assign drive_common = res_reg.drive_common;
    assign current_temp = res_reg.current_temp;

    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(drive_open && drive_close))
        else $error("both direction relays driven");

    a_common_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_common == (drive_open || drive_close)))
        else $error("common relay out of step with direction relays");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("stepped beat did not reach result register");

endmodule

`default_nettype wire
